@@ sv/longest_subarray_sum_at_least_unit_macros.svh @@
// Assertion macros for the block's top module.
`ifndef LONGEST_SUBARRAY_SUM_AT_LEAST_UNIT_MACROS_SVH
`define LONGEST_SUBARRAY_SUM_AT_LEAST_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define LSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define LSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/lss_pkg.sv @@
`timescale 1ns / 1ps
package lss_pkg;
    localparam int MaxItems = 1024;
    localparam int IdxW = $clog2(MaxItems);
    localparam int CntW = IdxW + 1;
    localparam int ValW = 32;
    localparam int SumW = 42;
    localparam int PosW = 11;

    typedef struct packed {
        logic signed [ValW-1:0] value;
        logic                   last;
    } in_word_t;

    typedef struct packed {
        logic            found;
        logic [PosW-1:0] first_pos;
        logic [PosW-1:0] last_pos;
        logic [PosW-1:0] length;
    } out_word_t;
endpackage

@@ sv/lss_ram.sv @@
`timescale 1ns / 1ps
// Simple single-port RAM with registered read data.
module lss_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write and registered read on one port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ sv/longest_subarray_sum_at_least_unit.sv @@
`timescale 1ns / 1ps
// After the closing word the block evaluates the n loaded elements; the insertion sort
// over the single-port prefix store dominates the evaluation time.
// Throughput: loading takes one word per cycle while no result is pending; evaluation
// runs one step per cycle through single-port memories, with in_stall held high.
// Reset (rst_n, asynchronous, low) clears the sequencer, element count, threshold
// and output valid flag; the memories keep their contents and need no clearing.
module longest_subarray_sum_at_least_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  lss_pkg::in_word_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output lss_pkg::out_word_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic signed [lss_pkg::SumW-1:0] cfg_data
);
    import lss_pkg::*;
    `include "longest_subarray_sum_at_least_unit_macros.svh"

    typedef enum logic [4:0] {
        S_LOAD, S_PRE_RD, S_PRE_WR, S_SORT_I, S_SORT_RK, S_SORT_RP, S_SORT_CMP,
        S_SORT_INS, S_MIN_RD, S_MIN_WR, S_SRCH_I, S_SRCH_P, S_SRCH_MID, S_SRCH_RS,
        S_SRCH_CMP, S_SRCH_MRD, S_SRCH_UPD, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic signed [SumW-1:0] thr_reg;
    logic signed [SumW-1:0] acc_reg, acc_next;
    logic signed [SumW:0] key_reg, key_next;
    logic [CntW-1:0] i_reg, i_next, k_reg, k_next;
    logic [CntW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [IdxW-1:0] hit_reg, hit_next, tmp_reg, tmp_next;
    logic any_reg, any_next;
    logic [PosW-1:0] best_reg, best_next, bf_reg, bf_next, bl_reg, bl_next;
    logic ov_reg;
    out_word_t od_reg;

    // Memory ports.
    logic e_we, p_we, s_we, m_we;
    logic [IdxW-1:0] e_a, p_a, s_a, m_a;
    logic [ValW-1:0] e_wd, e_rd;
    logic [SumW-1:0] p_wd, p_rd;
    logic [IdxW-1:0] s_wd, s_rd, m_wd, m_rd;

    lss_ram #(.Width(ValW), .Depth(MaxItems)) u_elem
        (.clk(clk), .we(e_we), .addr(e_a), .wdata(e_wd), .rdata(e_rd));
    lss_ram #(.Width(SumW), .Depth(MaxItems)) u_pre
        (.clk(clk), .we(p_we), .addr(p_a), .wdata(p_wd), .rdata(p_rd));
    lss_ram #(.Width(IdxW), .Depth(MaxItems)) u_sidx
        (.clk(clk), .we(s_we), .addr(s_a), .wdata(s_wd), .rdata(s_rd));
    lss_ram #(.Width(IdxW), .Depth(MaxItems)) u_midx
        (.clk(clk), .we(m_we), .addr(m_a), .wdata(m_wd), .rdata(m_rd));

    logic in_acc, out_acc;
    logic signed [SumW-1:0] p_sig;
    logic signed [SumW+1:0] diff;
    logic [CntW-1:0] n_eff;

    assign in_acc = in_valid && !in_stall;
    assign out_acc = ov_reg && !out_stall;
    assign in_stall = (state_reg != S_LOAD) || ov_reg;
    assign cfg_ready = (state_reg == S_LOAD) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data = od_reg;
    assign p_sig = $signed(p_rd);
    assign n_eff = count_reg;

    // Sequencer next state and memory control.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        acc_next = acc_reg;
        key_next = key_reg;
        i_next = i_reg;
        k_next = k_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        mid_next = mid_reg;
        hit_next = hit_reg;
        tmp_next = tmp_reg;
        any_next = any_reg;
        best_next = best_reg;
        bf_next = bf_reg;
        bl_next = bl_reg;
        e_we = 1'b0; p_we = 1'b0; s_we = 1'b0; m_we = 1'b0;
        e_a = i_reg[IdxW-1:0]; p_a = i_reg[IdxW-1:0];
        s_a = k_reg[IdxW-1:0]; m_a = i_reg[IdxW-1:0];
        e_wd = in_data.value; p_wd = acc_reg;
        s_wd = tmp_reg; m_wd = tmp_reg;
        diff = '0;
        case (state_reg)
            S_LOAD:
            begin
                e_a = count_reg[IdxW-1:0];
                if (in_acc)
                begin
                    if (count_reg < CntW'(MaxItems))
                    begin
                        e_we = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (in_data.last)
                    begin
                        i_next = '0;
                        acc_next = '0;
                        state_next = S_PRE_RD;
                    end
                end
            end
            // Prefix sums: read element, add, write.
            S_PRE_RD:
            begin
                if (i_reg == n_eff)
                begin
                    i_next = '0;
                    state_next = S_SORT_I;
                end
                else
                begin
                    state_next = S_PRE_WR;
                end
            end
            S_PRE_WR:
            begin
                acc_next = acc_reg + SumW'($signed(e_rd));
                p_we = 1'b1;
                p_wd = acc_reg + SumW'($signed(e_rd));
                i_next = i_reg + 1'b1;
                state_next = S_PRE_RD;
            end
            // Insertion sort: key = P[i], shift while P[s[k-1]] > key.
            S_SORT_I:
            begin
                if (i_reg == n_eff)
                begin
                    i_next = '0;
                    state_next = S_MIN_RD;
                end
                else
                begin
                    k_next = i_reg;
                    state_next = S_SORT_RK;
                end
            end
            S_SORT_RK:
            begin
                key_next = (SumW+1)'(p_sig);
                if (k_reg == '0)
                begin
                    state_next = S_SORT_INS;
                end
                else
                begin
                    s_a = IdxW'(k_reg - 1'b1);
                    state_next = S_SORT_RP;
                end
            end
            S_SORT_RP:
            begin
                if (i_reg == '0)
                begin
                    key_next = (SumW+1)'(p_sig);
                end
                p_a = s_rd;
                tmp_next = s_rd;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                if ((SumW+1)'(p_sig) > key_reg)
                begin
                    s_we = 1'b1;
                    s_wd = tmp_reg;
                    k_next = k_reg - 1'b1;
                    state_next = S_SORT_RK;
                    p_a = i_reg[IdxW-1:0];
                end
                else
                begin
                    state_next = S_SORT_INS;
                end
            end
            S_SORT_INS:
            begin
                s_we = 1'b1;
                s_wd = i_reg[IdxW-1:0];
                i_next = i_reg + 1'b1;
                state_next = S_SORT_I;
            end
            // Running minimum of index over the sorted order.
            S_MIN_RD:
            begin
                s_a = i_reg[IdxW-1:0];
                if (i_reg == n_eff)
                begin
                    i_next = '0;
                    best_next = '0; bf_next = '0; bl_next = '0;
                    state_next = S_SRCH_I;
                end
                else
                begin
                    state_next = S_MIN_WR;
                end
            end
            S_MIN_WR:
            begin
                m_we = 1'b1;
                m_wd = (i_reg != '0 && tmp_reg < s_rd) ? tmp_reg : s_rd;
                tmp_next = m_wd;
                i_next = i_reg + 1'b1;
                state_next = S_MIN_RD;
            end
            // Per-end binary search.
            S_SRCH_I:
            begin
                if (i_reg == n_eff)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SRCH_P;
                end
            end
            S_SRCH_P:
            begin
                if (p_sig >= thr_reg)
                begin
                    best_next = PosW'(i_reg + 1'b1);
                    bf_next = PosW'(1);
                    bl_next = PosW'(i_reg + 1'b1);
                    i_next = i_reg + 1'b1;
                    state_next = S_SRCH_I;
                end
                else
                begin
                    diff = (SumW+2)'(p_sig) - (SumW+2)'(thr_reg);
                    key_next = (SumW+1)'(diff);
                    lo_next = '0;
                    hi_next = n_eff;
                    any_next = 1'b0;
                    state_next = S_SRCH_MID;
                end
            end
            S_SRCH_MID:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next = lo_reg + ((hi_reg - lo_reg) >> 1);
                    s_a = IdxW'(lo_reg + ((hi_reg - lo_reg) >> 1));
                    state_next = S_SRCH_RS;
                end
                else if (any_reg)
                begin
                    m_a = hit_reg;
                    state_next = S_SRCH_MRD;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_SRCH_I;
                end
            end
            S_SRCH_RS:
            begin
                p_a = s_rd;
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                // P - thr needs SumW+1 bits; compare in the wider domain.
                if ((SumW+2)'(p_sig) <= (SumW+2)'(key_reg))
                begin
                    hit_next = mid_reg[IdxW-1:0];
                    any_next = 1'b1;
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH_MID;
            end
            S_SRCH_MRD:
            begin
                // Keep the minimum-index address so the read data stays valid.
                m_a = hit_reg;
                state_next = S_SRCH_UPD;
            end
            S_SRCH_UPD:
            begin
                if (CntW'(m_rd) < i_reg
                    && PosW'(i_reg - CntW'(m_rd)) > best_reg)
                begin
                    best_next = PosW'(i_reg - CntW'(m_rd));
                    bf_next = PosW'(m_rd) + PosW'(2);
                    bl_next = PosW'(i_reg + 1'b1);
                end
                i_next = i_reg + 1'b1;
                state_next = S_SRCH_I;
            end
            S_OUT:
            begin
                count_next = '0;
                state_next = S_LOAD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
        if (state_reg == S_SRCH_I || state_reg == S_SORT_I)
        begin
            p_a = i_reg[IdxW-1:0];
        end
        if (state_reg == S_MIN_WR)
        begin
            m_a = i_reg[IdxW-1:0];
        end
    end

    // State, counters, threshold and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            thr_reg <= '0;
            ov_reg <= 1'b0;
            i_reg <= '0;
            best_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg <= i_next;
            best_reg <= best_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
            if (state_reg == S_OUT)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        key_reg <= key_next;
        k_reg <= k_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        mid_reg <= mid_next;
        hit_reg <= hit_next;
        tmp_reg <= tmp_next;
        any_reg <= any_next;
        bf_reg <= bf_next;
        bl_reg <= bl_next;
        if (state_reg == S_OUT)
        begin
            od_reg.found <= (best_reg != '0);
            od_reg.first_pos <= bf_reg;
            od_reg.last_pos <= bl_reg;
            od_reg.length <= best_reg;
        end
    end

    `LSS_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CntW'(MaxItems))
    `LSS_ASSERT_IMP(a_busy_stalls, state_reg != S_LOAD, in_stall)
    `LSS_ASSERT_NEXT(a_out_then_load, state_reg == S_OUT, state_reg == S_LOAD && ov_reg)
    `LSS_ASSERT_IMP(a_no_cfg_busy, ov_reg, !cfg_ready)
endmodule
